/* rtl/ultrasonic_emergency_brake_unit_defines.svh */
// assertion macros for the emergency brake unit
`ifndef ULTRASONIC_EMERGENCY_BRAKE_UNIT_DEFINES_SVH
`define ULTRASONIC_EMERGENCY_BRAKE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UEB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ueb_pkg.sv */
// shared types, constants and the sector table of the emergency brake unit
package ueb_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int SUM_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int NUM_LANES     = 8;
    localparam int NUM_FRONT     = 5;

    localparam logic [15:0]        NEAR_LIMIT = 16'd13;
    localparam logic [15:0]        BASE_RESET = 16'd128;
    localparam logic signed [15:0] STOP_RESET = 16'sd90;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_STOP = 1'b1;

    localparam logic [3:0] SECTOR_NONE       = 4'd0;
    localparam logic [3:0] SECTOR_FWD_LEFT   = 4'd1;
    localparam logic [3:0] SECTOR_FWD_CLEFT  = 4'd2;
    localparam logic [3:0] SECTOR_FWD_CENTER = 4'd3;
    localparam logic [3:0] SECTOR_FWD_CRIGHT = 4'd4;
    localparam logic [3:0] SECTOR_FWD_RIGHT  = 4'd5;
    localparam logic [3:0] SECTOR_REV_LEFT   = 4'd6;
    localparam logic [3:0] SECTOR_REV_CENTER = 4'd7;
    localparam logic [3:0] SECTOR_REV_RIGHT  = 4'd8;

    localparam logic [7:0] ANGLE_FWD_LEFT_END  = 8'd65;
    localparam logic [7:0] ANGLE_CENTER_LO     = 8'd80;
    localparam logic [7:0] ANGLE_CENTER_HI     = 8'd100;
    localparam logic [7:0] ANGLE_FWD_CRIGHT_HI = 8'd115;
    localparam logic [7:0] ANGLE_REV_LEFT_END  = 8'd75;
    localparam logic [7:0] ANGLE_REV_RIGHT_LO  = 8'd105;

    typedef enum logic [2:0] {
        OP_SPEED   = 3'd0,
        OP_ANGLE   = 3'd1,
        OP_FRAME   = 3'd2,
        OP_COMMAND = 3'd3,
        OP_ENABLE  = 3'd4,
        OP_DISABLE = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_KEEP   = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_THIRTY = 2'd2,
        KIND_NEAR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic               speed_valid;
        logic signed [15:0] speed_out;
        logic               status_valid;
        logic               braking;
    } t_result;

    // threshold kind of a front lane for the current sector
    function automatic t_kind front_kind(input logic [3:0] sec, input logic [2:0] lane);
        t_kind k;
        k = KIND_KEEP;
        case (sec)
            SECTOR_FWD_LEFT: begin
                case (lane)
                    3'd0:    k = KIND_FULL;
                    3'd1:    k = KIND_THIRTY;
                    default: k = KIND_KEEP;
                endcase
            end
            SECTOR_FWD_CLEFT: begin
                case (lane)
                    3'd0:    k = KIND_THIRTY;
                    3'd1:    k = KIND_FULL;
                    3'd2:    k = KIND_THIRTY;
                    default: k = KIND_KEEP;
                endcase
            end
            SECTOR_FWD_CENTER: begin
                case (lane)
                    3'd0:    k = KIND_NEAR;
                    3'd1:    k = KIND_THIRTY;
                    3'd2:    k = KIND_FULL;
                    3'd3:    k = KIND_THIRTY;
                    3'd4:    k = KIND_NEAR;
                    default: k = KIND_KEEP;
                endcase
            end
            SECTOR_FWD_CRIGHT: begin
                case (lane)
                    3'd2:    k = KIND_THIRTY;
                    3'd3:    k = KIND_FULL;
                    3'd4:    k = KIND_THIRTY;
                    default: k = KIND_KEEP;
                endcase
            end
            SECTOR_FWD_RIGHT: begin
                case (lane)
                    3'd3:    k = KIND_THIRTY;
                    3'd4:    k = KIND_FULL;
                    default: k = KIND_KEEP;
                endcase
            end
            default: k = KIND_KEEP;
        endcase
        return k;
    endfunction

endpackage

/* rtl/ultrasonic_emergency_brake_unit.sv */
// top level of the ultrasonic emergency brake unit
// Takes one item per clock while input ready is high. Eight threshold lanes
// and the speed square (one 16x16 multiply with saturate and compare) resolve
// an item in the cycle it is accepted; a result, where there is one, is
// registered into a two-entry result queue that drives the output. Input
// ready drops only while that queue holds two undelivered results.
// Configuration is an APB port with base_min_distance at address 0 and
// stop_value at address 4. No clearing pass after reset.
`include "ultrasonic_emergency_brake_unit_defines.svh"
module ultrasonic_emergency_brake_unit import ueb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [15:0] i_measured_speed,
    input  logic [7:0]         i_steer_angle,
    input  logic signed [15:0] i_speed_command,
    input  logic [15:0]        i_dist_front_left,
    input  logic [15:0]        i_dist_front_center_left,
    input  logic [15:0]        i_dist_front_center,
    input  logic [15:0]        i_dist_front_center_right,
    input  logic [15:0]        i_dist_front_right,
    input  logic [15:0]        i_dist_rear_left,
    input  logic [15:0]        i_dist_rear_center,
    input  logic [15:0]        i_dist_rear_right,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_speed_valid,
    output logic signed [15:0] o_speed_out,
    output logic               o_status_valid,
    output logic               o_braking
);

    logic [15:0]        r_base_min;
    logic signed [15:0] r_stop_value;
    logic               r_active;
    logic [7:0]         r_sensor_flags;
    logic               r_moving_forward;
    logic [3:0]         r_sector;
    logic [15:0]        r_stop_distance;

    logic               w_accept;
    logic               w_cfg_write;
    t_op                w_op;
    logic               w_full;
    logic [15:0]        w_dist [NUM_LANES];
    logic [7:0]         w_lane_flag;
    logic               w_neg;
    logic [15:0]        w_mag;
    logic [31:0]        w_square;
    logic [15:0]        w_half;
    logic [15:0]        w_new_stop;
    logic [3:0]         w_new_sector;
    logic               w_decision;
    logic               w_cmd;
    logic               w_disable;
    logic               w_res_valid;
    t_result            w_res;
    t_result            w_out;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_accept    = i_valid && o_ready;
    assign o_ready     = !w_full;
    assign w_op        = t_op'(i_op);

    always_comb begin
        case (paddr[2])
            REG_BASE: prdata = {16'd0, r_base_min};
            REG_STOP: prdata = {{16{r_stop_value[15]}}, r_stop_value};
            default:  prdata = '0;
        endcase
    end

    // stop distance from the speed: max(base, v*v/512), saturated
    assign w_neg      = i_measured_speed[15];
    assign w_mag      = w_neg ? 16'(-i_measured_speed) : 16'(i_measured_speed);
    assign w_square   = w_mag * w_mag;
    assign w_half     = (|w_square[31:25]) ? 16'hFFFF : w_square[24:9];
    assign w_new_stop = (w_half < r_base_min) ? r_base_min : w_half;

    // sector; backward gaps keep the old one
    always_comb begin
        w_new_sector = r_sector;
        if (r_moving_forward) begin
            if (i_steer_angle < ANGLE_FWD_LEFT_END) begin
                w_new_sector = SECTOR_FWD_LEFT;
            end else if (i_steer_angle < ANGLE_CENTER_LO) begin
                w_new_sector = SECTOR_FWD_CLEFT;
            end else if (i_steer_angle <= ANGLE_CENTER_HI) begin
                w_new_sector = SECTOR_FWD_CENTER;
            end else if (i_steer_angle <= ANGLE_FWD_CRIGHT_HI) begin
                w_new_sector = SECTOR_FWD_CRIGHT;
            end else begin
                w_new_sector = SECTOR_FWD_RIGHT;
            end
        end else begin
            if (i_steer_angle < ANGLE_REV_LEFT_END) begin
                w_new_sector = SECTOR_REV_LEFT;
            end else if (i_steer_angle inside {[ANGLE_CENTER_LO:ANGLE_CENTER_HI]}) begin
                w_new_sector = SECTOR_REV_CENTER;
            end else if (i_steer_angle > ANGLE_REV_RIGHT_LO) begin
                w_new_sector = SECTOR_REV_RIGHT;
            end
        end
    end

    assign w_dist[0] = i_dist_front_left;
    assign w_dist[1] = i_dist_front_center_left;
    assign w_dist[2] = i_dist_front_center;
    assign w_dist[3] = i_dist_front_center_right;
    assign w_dist[4] = i_dist_front_right;
    assign w_dist[5] = i_dist_rear_left;
    assign w_dist[6] = i_dist_rear_center;
    assign w_dist[7] = i_dist_rear_right;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        t_kind w_kind;
        assign w_kind = (g < NUM_FRONT) ? front_kind(r_sector, 3'(g)) : KIND_FULL;
        ueb_lane u_lane (
            .i_kind      (w_kind),
            .i_dist      (w_dist[g]),
            .i_stop_dist (r_stop_distance),
            .i_flag      (r_sensor_flags[g]),
            .o_flag      (w_lane_flag[g])
        );
    end

    assign w_decision = ((|r_sensor_flags[NUM_FRONT-1:0]) && r_moving_forward) ||
                        ((|r_sensor_flags[NUM_LANES-1:NUM_FRONT]) && !r_moving_forward);
    assign w_cmd      = w_accept && r_active && (w_op == OP_COMMAND);
    assign w_disable  = w_accept && (w_op == OP_DISABLE);

    ueb_decide u_decide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_disable       (w_disable),
        .i_decision      (w_decision),
        .i_speed_command (i_speed_command),
        .i_stop_value    (r_stop_value),
        .o_result_valid  (w_res_valid),
        .o_result        (w_res)
    );

    ueb_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_speed_valid  = w_out.speed_valid;
    assign o_speed_out    = w_out.speed_out;
    assign o_status_valid = w_out.status_valid;
    assign o_braking      = w_out.braking;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_min       <= BASE_RESET;
            r_stop_value     <= STOP_RESET;
            r_active         <= 1'b1;
            r_sensor_flags   <= '0;
            r_moving_forward <= 1'b1;
            r_sector         <= SECTOR_FWD_CENTER;
            r_stop_distance  <= BASE_RESET;
        end else begin
            if (w_cfg_write) begin
                case (paddr[2])
                    REG_BASE: r_base_min   <= pwdata[15:0];
                    REG_STOP: r_stop_value <= pwdata[15:0];
                    default:  r_base_min   <= r_base_min;
                endcase
            end
            if (w_accept) begin
                case (w_op)
                    OP_SPEED: begin
                        if (r_active) begin
                            r_stop_distance <= w_new_stop;
                            if (r_sensor_flags == '0) begin
                                r_moving_forward <= !w_neg;
                            end
                        end
                    end
                    OP_ANGLE: begin
                        if (r_active) begin
                            r_sector <= w_new_sector;
                        end
                    end
                    OP_FRAME: begin
                        if (r_active) begin
                            r_sensor_flags <= w_lane_flag;
                        end
                    end
                    OP_ENABLE: begin
                        r_active <= 1'b1;
                    end
                    OP_DISABLE: begin
                        r_active         <= 1'b0;
                        r_sensor_flags   <= '0;
                        r_moving_forward <= 1'b1;
                    end
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
        end
    end

    `UEB_ASSERT_NEXT(a_disable_gives_result, w_disable, o_valid, "disable item left no result")
    `UEB_ASSERT_NOW(a_idle_flags_clear, !r_active, r_sensor_flags == '0, "flags set while guard off")
    `UEB_ASSERT_NEXT(a_idle_flags_hold, w_accept && !r_active && w_op != OP_DISABLE, $stable(r_sensor_flags), "flags moved while guard off")
    `UEB_ASSERT_NOW(a_brake_sends_speed, o_valid && o_braking, o_speed_valid, "braking result without speed")

endmodule

/* rtl/ueb_lane.sv */
// one sensor lane: compares a distance with the selected threshold, or keeps its old flag
module ueb_lane import ueb_pkg::*; (
    input  t_kind       i_kind,
    input  logic [15:0] i_dist,
    input  logic [15:0] i_stop_dist,
    input  logic        i_flag,
    output logic        o_flag
);

    logic [19:0] w_dist_x10;
    logic [19:0] w_stop_x3;
    logic        w_hit;

    assign w_dist_x10 = ({4'd0, i_dist} << 3) + ({4'd0, i_dist} << 1);
    assign w_stop_x3  = ({4'd0, i_stop_dist} << 1) + {4'd0, i_stop_dist};

    always_comb begin
        case (i_kind)
            KIND_FULL:   w_hit = i_dist < i_stop_dist;
            KIND_THIRTY: w_hit = w_dist_x10 < w_stop_x3;
            KIND_NEAR:   w_hit = i_dist < NEAR_LIMIT;
            default:     w_hit = i_flag;
        endcase
    end

    assign o_flag = w_hit;

endmodule

/* rtl/ueb_decide.sv */
// merging stage: decision history, brake latch and result forming
module ueb_decide import ueb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd,
    input  logic               i_disable,
    input  logic               i_decision,
    input  logic signed [15:0] i_speed_command,
    input  logic signed [15:0] i_stop_value,
    output logic               o_result_valid,
    output t_result            o_result
);

    logic [HISTORY_DEPTH-1:0] r_history;
    logic [HISTORY_DEPTH-1:0] n_history;
    logic                     r_latched;
    logic                     n_latched;
    logic [HISTORY_DEPTH:0]   w_shifted;
    logic [SUM_W-1:0]         w_sum;

    assign w_shifted = {r_history, i_decision};

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            w_sum = w_sum + SUM_W'(w_shifted[k]);
        end
    end

    always_comb begin
        n_history      = r_history;
        n_latched      = r_latched;
        o_result_valid = 1'b0;
        o_result       = '0;
        if (i_disable) begin
            n_history             = '0;
            n_latched             = 1'b0;
            o_result_valid        = 1'b1;
            o_result.status_valid = 1'b1;
        end else if (i_cmd) begin
            n_history = w_shifted[HISTORY_DEPTH-1:0];
            if ((w_sum == SUM_W'(1) && !r_latched) || (w_sum != '0 && r_latched)) begin
                n_latched            = 1'b1;
                o_result_valid       = 1'b1;
                o_result.speed_valid = 1'b1;
                o_result.speed_out   = i_stop_value;
            end else if ((w_sum == '0 && r_latched) ||
                         (w_sum < SUM_W'(HISTORY_DEPTH) && !r_latched)) begin
                n_latched            = 1'b0;
                o_result_valid       = 1'b1;
                o_result.speed_valid = 1'b1;
                o_result.speed_out   = i_speed_command;
            end
            o_result.status_valid = n_latched != r_latched;
            o_result.braking      = n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
            r_latched <= 1'b0;
        end else begin
            r_history <= n_history;
            r_latched <= n_latched;
        end
    end

endmodule

/* rtl/ueb_out_buf.sv */
// two-entry result queue between the core and the output channel
module ueb_out_buf import ueb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;
    logic [1:0] w_slot;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign w_slot  = r_cnt - {1'b0, w_pop};
    assign n_cnt   = w_slot + {1'b0, i_push};
    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a push into slot zero overrides the shift
    always_ff @(posedge i_clk) begin
        if (i_push && (w_slot == 2'd0)) begin
            r_q0 <= i_data;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
        if (i_push && (w_slot != 2'd0)) begin
            r_q1 <= i_data;
        end
    end

endmodule
